// ===== hw/rtl/ttp_pkg.sv =====
// Package: table geometry, slot record, opcodes and sequencer states for the probe block.
package ttp_pkg;

   localparam int unsigned TABLE_SIZE = 1024;
   localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
   localparam int unsigned CNT_W      = IDX_W + 1;

   localparam int unsigned KEY_W   = 64;
   localparam int unsigned PLY_W   = 16;
   localparam int unsigned OP_W    = 2;
   localparam int unsigned SLOT_W  = 10;
   localparam int unsigned USED_W  = 11;
   localparam int unsigned FILL_W  = 10;

   localparam int unsigned PERMILLE = 1000;
   localparam int unsigned PROD_W   = CNT_W + $clog2(PERMILLE + 1);

   typedef enum logic [OP_W-1:0] {
      OP_FIND_CREATE = 2'd0,
      OP_FIND        = 2'd1,
      OP_CLEAR       = 2'd2,
      OP_NOP         = 2'd3
   } opcode_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [PLY_W-1:0] ply;
   } slot_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_CLEAR,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/transposition_table_probe.sv =====
// Top level: transposition table probe, a linear-probing hash table held in one slot memory.
//
// The table keeps TABLE_SIZE slots (valid bit, 64-bit key, 16-bit ply) in a single
// synchronous memory with one write port and one registered read port. One item is
// worked on at a time. Each probe step reads the slot, then checks it and writes back
// if the slot is claimed or overwritten; a lookup probes at most TABLE_SIZE slots, a
// full wrap. A clear item sweeps the memory one slot per cycle. A no-operation item
// goes straight to the result. After reset the same sweep runs once while req_stall
// stays high; csr writes are taken at any time. The result sits in an output
// register, so the next item is accepted while an earlier result still waits on
// rsp_stall. fill_permille is used_count * 1000 / TABLE_SIZE, truncated.
// obsolete_ply may only be written while no item is in work.
module transposition_table_probe (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ttp_pkg::OP_W-1:0]      req_opcode,
   input  logic [ttp_pkg::KEY_W-1:0]     req_search_key,
   input  logic [ttp_pkg::PLY_W-1:0]     req_ply,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_created,
   output logic                          rsp_full_res,
   output logic [ttp_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic [ttp_pkg::USED_W-1:0]    rsp_used_count,
   output logic [ttp_pkg::FILL_W-1:0]    rsp_fill_permille,

   input  logic                          csr_wr_en,
   input  logic [ttp_pkg::PLY_W-1:0]     csr_wr_data
);

   // slot memory
   ttp_pkg::slot_type                    mem [ttp_pkg::TABLE_SIZE];
   ttp_pkg::slot_type                    rd_data_ff;
   logic                                 mem_we;
   logic [ttp_pkg::IDX_W-1:0]            mem_wa;
   ttp_pkg::slot_type                    mem_wd;

   // sequencer
   ttp_pkg::state_type                   state_ff;
   ttp_pkg::state_type                   state_in;

   // item in work
   ttp_pkg::opcode_type                  op_ff;
   logic [ttp_pkg::KEY_W-1:0]            key_ff;
   logic [ttp_pkg::PLY_W-1:0]            ply_ff;
   logic [ttp_pkg::IDX_W-1:0]            idx_ff;
   logic [ttp_pkg::IDX_W-1:0]            probe_cnt_ff;
   logic [ttp_pkg::IDX_W-1:0]            clr_idx_ff;

   // table-wide state
   logic [ttp_pkg::CNT_W-1:0]            occ_ff;
   logic [ttp_pkg::PLY_W-1:0]            obsolete_ff;

   // pending result
   logic                                 res_hit_ff;
   logic                                 res_created_ff;
   logic                                 res_full_ff;
   logic [ttp_pkg::IDX_W-1:0]            res_slot_ff;

   // output register
   logic                                 rsp_valid_ff;
   logic                                 rsp_hit_ff;
   logic                                 rsp_created_ff;
   logic                                 rsp_full_ff;
   logic [ttp_pkg::SLOT_W-1:0]           rsp_slot_ff;
   logic [ttp_pkg::USED_W-1:0]           rsp_used_ff;
   logic [ttp_pkg::FILL_W-1:0]           rsp_fill_ff;

   // decode
   logic                                 accept;
   logic                                 out_free;
   logic                                 is_create;
   logic                                 slot_stale;
   logic                                 slot_match;
   logic                                 slot_empty;
   logic                                 probe_done;
   logic                                 probe_last;
   logic                                 clr_last;
   logic [ttp_pkg::PROD_W-1:0]           fill_prod;

   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign is_create  = (op_ff == ttp_pkg::OP_FIND_CREATE);
   assign slot_stale = rd_data_ff.valid && is_create && (rd_data_ff.ply < obsolete_ff);
   assign slot_match = rd_data_ff.valid && (rd_data_ff.key == key_ff)
                       && (rd_data_ff.ply == ply_ff);
   assign slot_empty = !rd_data_ff.valid;
   // An empty slot ends any lookup; stale wins over match when both apply.
   assign probe_done = slot_stale || slot_match || slot_empty;
   assign probe_last = (probe_cnt_ff == {ttp_pkg::IDX_W{1'b1}});
   assign clr_last   = (clr_idx_ff == {ttp_pkg::IDX_W{1'b1}});
   assign fill_prod  = ttp_pkg::PROD_W'(occ_ff) * ttp_pkg::PROD_W'(ttp_pkg::PERMILLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ttp_pkg::ST_INIT: begin
            if (clr_last) state_in = ttp_pkg::ST_IDLE;
         end
         ttp_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (ttp_pkg::opcode_type'(req_opcode))
                  ttp_pkg::OP_CLEAR:       state_in = ttp_pkg::ST_CLEAR;
                  ttp_pkg::OP_NOP:         state_in = ttp_pkg::ST_DONE;
                  ttp_pkg::OP_FIND_CREATE,
                  ttp_pkg::OP_FIND:        state_in = ttp_pkg::ST_READ;
               endcase
            end
         end
         ttp_pkg::ST_READ:  state_in = ttp_pkg::ST_CHECK;
         ttp_pkg::ST_CHECK: begin
            if (probe_done || probe_last) state_in = ttp_pkg::ST_DONE;
            else                          state_in = ttp_pkg::ST_READ;
         end
         ttp_pkg::ST_CLEAR: begin
            if (clr_last) state_in = ttp_pkg::ST_DONE;
         end
         ttp_pkg::ST_DONE: begin
            if (out_free) state_in = ttp_pkg::ST_IDLE;
         end
         default: state_in = ttp_pkg::ST_INIT;
      endcase
   end

   // Outputs of the sequencer: input stall and memory write port.
   always_comb begin
      req_stall = (state_ff != ttp_pkg::ST_IDLE);
      mem_we    = 1'b0;
      mem_wa    = idx_ff;
      mem_wd    = '{valid: 1'b1, key: key_ff, ply: ply_ff};
      unique case (state_ff)
         ttp_pkg::ST_INIT,
         ttp_pkg::ST_CLEAR: begin
            // wipe one slot per cycle
            mem_we = 1'b1;
            mem_wa = clr_idx_ff;
            mem_wd = '0;
         end
         ttp_pkg::ST_CHECK: begin
            // claim an empty slot or take over a stale one
            mem_we = slot_stale || (slot_empty && is_create);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Slot memory: one write port, registered read at the probe pointer.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[idx_ff];
   end

   // Sequencer state and control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttp_pkg::ST_INIT;
         clr_idx_ff   <= '0;
         occ_ff       <= '0;
         obsolete_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            obsolete_ff <= csr_wr_data;
         end

         // advance the sweep pointer
         if ((state_ff == ttp_pkg::ST_INIT) || (state_ff == ttp_pkg::ST_CLEAR)) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end

         if (accept && (ttp_pkg::opcode_type'(req_opcode) == ttp_pkg::OP_CLEAR)) begin
            occ_ff <= '0;
         end else if ((state_ff == ttp_pkg::ST_CHECK) && slot_empty && is_create) begin
            occ_ff <= occ_ff + 1'b1;
         end

         // drop the taken result, load the next one when the slot is free
         if (state_ff == ttp_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item and result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff          <= ttp_pkg::opcode_type'(req_opcode);
         key_ff         <= req_search_key;
         ply_ff         <= req_ply;
         idx_ff         <= req_search_key[ttp_pkg::IDX_W-1:0];
         probe_cnt_ff   <= '0;
         res_hit_ff     <= 1'b0;
         res_created_ff <= 1'b0;
         res_full_ff    <= 1'b0;
         res_slot_ff    <= '0;
      end

      if (state_ff == ttp_pkg::ST_CHECK) begin
         if (slot_stale) begin
            res_created_ff <= 1'b1;
            res_slot_ff    <= idx_ff;
         end else if (slot_match) begin
            res_hit_ff     <= 1'b1;
            res_slot_ff    <= idx_ff;
         end else if (slot_empty) begin
            res_created_ff <= is_create;
            res_slot_ff    <= is_create ? idx_ff : '0;
         end else if (probe_last) begin
            res_full_ff    <= 1'b1;
         end else begin
            // step to the next slot, wrapping at the table end
            idx_ff         <= idx_ff + 1'b1;
            probe_cnt_ff   <= probe_cnt_ff + 1'b1;
         end
      end

      if (state_ff == ttp_pkg::ST_DONE && out_free) begin
         rsp_hit_ff     <= res_hit_ff;
         rsp_created_ff <= res_created_ff;
         rsp_full_ff    <= res_full_ff;
         rsp_slot_ff    <= ttp_pkg::SLOT_W'(res_slot_ff);
         rsp_used_ff    <= ttp_pkg::USED_W'(occ_ff);
         rsp_fill_ff    <= ttp_pkg::FILL_W'(fill_prod >> ttp_pkg::IDX_W);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_created       = rsp_created_ff;
   assign rsp_full_res      = rsp_full_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_used_count    = rsp_used_ff;
   assign rsp_fill_permille = rsp_fill_ff;

endmodule
